// ----- sv/utrp_pkg.sv -----
// Shared types, codes, block encodings and the microcode program of the
// transfer ring producer. No dependencies; imported by every module.
`timescale 1ns / 1ps
`default_nettype none

package utrp_pkg;

    // Default sizing of the ring and of the buffer boundary (power of two)
    localparam int RING_ENTRIES_DEF   = 256;
    localparam int BOUNDARY_BYTES_DEF = 65536;

    // Input command codes
    localparam logic [1:0] CMD_BULK    = 2'd0;
    localparam logic [1:0] CMD_CONTROL = 2'd1;
    localparam logic [1:0] CMD_INTR    = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_BLOCK  = 2'd0;
    localparam logic [1:0] KIND_LINK   = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_RING_BASE = 2'd0;
    localparam logic [1:0] REG_BULK_LEN  = 2'd1;
    localparam logic [1:0] REG_CTRL_MAX  = 2'd2;

    localparam logic [16:0] BULK_LEN_RST = 17'h1_0000;
    localparam logic [15:0] CTRL_MAX_RST = 16'h1000;

    // Block control word: type field at bit 10 and flags
    localparam logic [31:0] BT_NORMAL   = 32'h0000_0400;
    localparam logic [31:0] BT_SETUP    = 32'h0000_0800;
    localparam logic [31:0] BT_DATA     = 32'h0000_0C00;
    localparam logic [31:0] BT_STATUS   = 32'h0000_1000;
    localparam logic [31:0] BT_LINK     = 32'h0000_1800;
    localparam logic [31:0] FLAG_IOC    = 32'h0000_0020;
    localparam logic [31:0] FLAG_CHAIN  = 32'h0000_0010;
    localparam logic [31:0] FLAG_IDT    = 32'h0000_0040;
    localparam logic [31:0] FLAG_ISP    = 32'h0000_0004;
    localparam logic [31:0] FLAG_TOGGLE = 32'h0000_0002;
    localparam logic [31:0] FLAG_DIR    = 32'h0001_0000;
    localparam logic [31:0] TRT_OUT     = 32'h0002_0000;
    localparam logic [31:0] TRT_IN      = 32'h0003_0000;
    localparam logic [31:0] SETUP_LEN   = 32'd8;

    // Sequencer program
    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_WAIT   = 3'd0;
    localparam step_t STEP_BULK   = 3'd1;
    localparam step_t STEP_SETUP  = 3'd2;
    localparam step_t STEP_DATA   = 3'd3;
    localparam step_t STEP_STATUS = 3'd4;
    localparam step_t STEP_INTR   = 3'd5;
    localparam step_t STEP_REJECT = 3'd6;

    typedef enum logic [2:0] {
        BLK_NONE,
        BLK_NORMAL,
        BLK_SETUP,
        BLK_DATA,
        BLK_STATUS,
        BLK_INTR,
        BLK_REJECT
    } blk_sel_t;

    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_DISPATCH,
        COND_MORE,
        COND_HAS_DATA
    } cond_t;

    typedef enum logic [1:0] {
        LAST_NEVER,
        LAST_ALWAYS,
        LAST_IF_NOT_COND
    } last_mode_t;

    typedef enum logic [1:0] {
        REQ_BULK,
        REQ_CONTROL,
        REQ_INTR,
        REQ_REJECT
    } req_kind_t;

    typedef struct packed {
        blk_sel_t   blk;
        cond_t      cond;
        last_mode_t last;
        step_t      jmp;
        step_t      fall;
    } ucode_t;

    // Sequencer to datapath
    typedef struct packed {
        logic     accept;
        logic     fire;
        blk_sel_t blk;
        logic     last;
    } seq_ctl_t;

    // Datapath to sequencer
    typedef struct packed {
        logic more;
        logic has_data;
        logic link_pend;
        logic can_emit;
    } dp_status_t;

    typedef struct packed {
        logic [31:0] control;
        logic [31:0] status;
        logic [63:0] param;
        logic [63:0] addr;
        logic [7:0]  slot;
        logic [1:0]  kind;
        logic        last;
    } result_t;

    // Microcode read-only table: one control word per step
    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t uw;
        case (step)
            STEP_WAIT:   uw = '{BLK_NONE,   COND_DISPATCH, LAST_NEVER,       STEP_WAIT,
                                STEP_WAIT};
            STEP_BULK:   uw = '{BLK_NORMAL, COND_MORE,     LAST_IF_NOT_COND, STEP_BULK,
                                STEP_WAIT};
            STEP_SETUP:  uw = '{BLK_SETUP,  COND_HAS_DATA, LAST_NEVER,       STEP_DATA,
                                STEP_STATUS};
            STEP_DATA:   uw = '{BLK_DATA,   COND_ALWAYS,   LAST_NEVER,       STEP_STATUS,
                                STEP_STATUS};
            STEP_STATUS: uw = '{BLK_STATUS, COND_ALWAYS,   LAST_ALWAYS,      STEP_WAIT,
                                STEP_WAIT};
            STEP_INTR:   uw = '{BLK_INTR,   COND_ALWAYS,   LAST_ALWAYS,      STEP_WAIT,
                                STEP_WAIT};
            STEP_REJECT: uw = '{BLK_REJECT, COND_ALWAYS,   LAST_ALWAYS,      STEP_WAIT,
                                STEP_WAIT};
            default:     uw = '{BLK_NONE,   COND_ALWAYS,   LAST_NEVER,       STEP_WAIT,
                                STEP_WAIT};
        endcase
        return uw;
    endfunction

    // Entry step of each request kind
    function automatic step_t dispatch_step(input req_kind_t kind);
        step_t s;
        case (kind)
            REQ_BULK:    s = STEP_BULK;
            REQ_CONTROL: s = STEP_SETUP;
            REQ_INTR:    s = STEP_INTR;
            default:     s = STEP_REJECT;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- sv/utrp_sequencer.sv -----
// Step counter and microcode control of the transfer ring producer.
// Depends on utrp_pkg (program table, control and status structs).
`timescale 1ns / 1ps
`default_nettype none

module utrp_sequencer
    import utrp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire req_kind_t  req_kind,
    input  wire dp_status_t stat,
    output seq_ctl_t        ctl
);

    step_t  step_reg;
    step_t  step_next;
    ucode_t uw;
    logic   wait_step;
    logic   accept;
    logic   fire;
    logic   cond_true;

    // Decode the current control word
    assign uw        = ucode_rom(step_reg);
    assign wait_step = (uw.cond == COND_DISPATCH);
    assign s_tready  = wait_step && !stat.link_pend;
    assign accept    = s_tvalid && s_tready;
    assign fire      = (uw.blk != BLK_NONE) && !stat.link_pend && stat.can_emit;

    always_comb
    begin
        case (uw.cond)
            COND_ALWAYS:   cond_true = 1'b1;
            COND_MORE:     cond_true = stat.more;
            COND_HAS_DATA: cond_true = stat.has_data;
            default:       cond_true = 1'b0;
        endcase
    end

    // Pick the next step: dispatch on a new transaction, branch after a push
    always_comb
    begin
        step_next = step_reg;
        if (wait_step)
        begin
            if (accept)
                step_next = dispatch_step(req_kind);
        end
        else if (fire)
        begin
            step_next = cond_true ? uw.jmp : uw.fall;
        end
    end

    assign ctl.accept = accept;
    assign ctl.fire   = fire;
    assign ctl.blk    = uw.blk;
    assign ctl.last   = (uw.last == LAST_ALWAYS) ||
                        ((uw.last == LAST_IF_NOT_COND) && !cond_true);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= STEP_WAIT;
        else
            step_reg <= step_next;
    end

endmodule

`default_nettype wire

// ----- sv/utrp_datapath.sv -----
// Request registers, block formation, ring index and cycle state, link
// insertion and the output register. Depends on utrp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module utrp_datapath
    import utrp_pkg::*;
#(
    parameter int RING_ENTRIES   = RING_ENTRIES_DEF,
    parameter int BOUNDARY_BYTES = BOUNDARY_BYTES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire seq_ctl_t    ctl,
    output dp_status_t       stat,
    output req_kind_t        req_kind,
    // request fields
    input  wire logic [1:0]  command,
    input  wire logic [63:0] buffer_address,
    input  wire logic [16:0] length,
    input  wire logic        direction_in,
    input  wire logic [7:0]  request_type,
    input  wire logic [7:0]  request_code,
    input  wire logic [15:0] request_value,
    input  wire logic [15:0] request_index,
    // configuration
    input  wire logic [63:0] ring_base_address,
    input  wire logic [16:0] bulk_buffer_length,
    input  wire logic [15:0] control_max_length,
    // result
    output logic             out_valid,
    input  wire logic        out_ready,
    output result_t          out_result
);

    localparam int IW = $clog2(RING_ENTRIES);
    localparam int LB = $clog2(BOUNDARY_BYTES);
    localparam int RW = LB + 1;
    localparam logic [IW-1:0] WRAP_IDX  = IW'(RING_ENTRIES - 2);
    localparam logic [IW-1:0] LINK_IDX  = IW'(RING_ENTRIES - 1);
    localparam logic [RW-1:0] BOUNDARY  = RW'(BOUNDARY_BYTES);
    localparam logic [18:0]   BULK_SPAN = 19'(3 * BOUNDARY_BYTES);

    // Latched request
    logic [63:0] cur_addr_reg;
    logic [16:0] rem_reg;
    logic [16:0] len_reg;
    logic        dir_reg;
    logic        cin_reg;
    logic [7:0]  rtype_reg;
    logic [7:0]  rcode_reg;
    logic [15:0] rvalue_reg;
    logic [15:0] rindex_reg;

    // Ring state
    logic [IW-1:0] idx_reg;
    logic          cycle_reg;
    logic          link_pend_reg;
    logic          link_chain_reg;
    logic          link_last_reg;

    // Output stage
    logic    out_valid_reg;
    result_t out_reg;

    logic          can_emit;
    logic          link_fire;
    logic [RW-1:0] room;
    logic          more;
    logic [16:0]   chunk;
    logic          over_span;
    logic [31:0]   blk_ctrl;
    logic [63:0]   blk_param;
    logic [31:0]   blk_status;
    logic          wrap;
    result_t       push_res;
    result_t       link_res;

    // Classify the offered request; rejection checks run on the input fields
    assign over_span = (19'(length) + 19'(buffer_address[LB-1:0])) > BULK_SPAN;

    always_comb
    begin
        case (command)
            CMD_BULK:
                req_kind = ((length > bulk_buffer_length) || over_span) ?
                           REQ_REJECT : REQ_BULK;
            CMD_CONTROL:
                req_kind = (length > {1'b0, control_max_length}) ? REQ_REJECT : REQ_CONTROL;
            CMD_INTR:
                req_kind = REQ_INTR;
            default:
                req_kind = REQ_REJECT;
        endcase
    end

    // Split the bulk transfer at the next boundary
    assign room  = BOUNDARY - RW'(cur_addr_reg[LB-1:0]);
    assign more  = rem_reg > 17'(room);
    assign chunk = more ? 17'(room) : rem_reg;

    assign can_emit  = !out_valid_reg || out_ready;
    assign link_fire = link_pend_reg && can_emit;

    assign stat.more      = more;
    assign stat.has_data  = (len_reg != 17'd0);
    assign stat.link_pend = link_pend_reg;
    assign stat.can_emit  = can_emit;

    // Form the block selected by the control word
    always_comb
    begin
        blk_param  = '0;
        blk_status = '0;
        blk_ctrl   = '0;
        case (ctl.blk)
            BLK_NORMAL:
            begin
                blk_param  = cur_addr_reg;
                blk_status = 32'(chunk);
                blk_ctrl   = BT_NORMAL | (more ? FLAG_CHAIN : FLAG_IOC) |
                             (dir_reg ? FLAG_ISP : 32'd0);
            end
            BLK_SETUP:
            begin
                blk_param  = {len_reg[15:0], rindex_reg, rvalue_reg, rcode_reg, rtype_reg};
                blk_status = SETUP_LEN;
                blk_ctrl   = BT_SETUP | FLAG_IDT |
                             ((len_reg == 17'd0) ? 32'd0 : (cin_reg ? TRT_IN : TRT_OUT));
            end
            BLK_DATA:
            begin
                blk_param  = cur_addr_reg;
                blk_status = 32'(len_reg);
                blk_ctrl   = BT_DATA | (cin_reg ? FLAG_DIR : 32'd0);
            end
            BLK_STATUS:
            begin
                blk_ctrl = BT_STATUS | FLAG_IOC |
                           (((len_reg != 17'd0) && cin_reg) ? 32'd0 : FLAG_DIR);
            end
            BLK_INTR:
            begin
                blk_param  = cur_addr_reg;
                blk_status = 32'(len_reg);
                blk_ctrl   = BT_NORMAL | FLAG_IOC | FLAG_ISP;
            end
            default:
            begin
                blk_param = '0;
            end
        endcase
    end

    assign wrap = (ctl.blk != BLK_REJECT) && (idx_reg == WRAP_IDX);

    // Result of a push: a transfer block, or the rejection marker
    always_comb
    begin
        if (ctl.blk == BLK_REJECT)
        begin
            push_res      = '0;
            push_res.kind = KIND_REJECT;
            push_res.last = 1'b1;
        end
        else
        begin
            push_res.kind    = KIND_BLOCK;
            push_res.slot    = 8'(idx_reg);
            push_res.addr    = ring_base_address + (64'(idx_reg) << 4);
            push_res.param   = blk_param;
            push_res.status  = blk_status;
            push_res.control = blk_ctrl | 32'(cycle_reg);
            push_res.last    = ctl.last && !wrap;
        end
    end

    // Link block update at the last ring slot
    always_comb
    begin
        link_res.kind    = KIND_LINK;
        link_res.slot    = 8'(LINK_IDX);
        link_res.addr    = ring_base_address + (64'(LINK_IDX) << 4);
        link_res.param   = ring_base_address;
        link_res.status  = 32'd0;
        link_res.control = BT_LINK | FLAG_TOGGLE | (link_chain_reg ? FLAG_CHAIN : 32'd0) |
                           32'(cycle_reg);
        link_res.last    = link_last_reg;
    end

    // Ring state: advance on a push, wrap and hold a link update, toggle on link
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            cycle_reg      <= 1'b1;
            link_pend_reg  <= 1'b0;
            link_chain_reg <= 1'b0;
            link_last_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (link_fire)
            begin
                link_pend_reg <= 1'b0;
                cycle_reg     <= ~cycle_reg;
            end
            else if (ctl.fire && (ctl.blk != BLK_REJECT))
            begin
                if (wrap)
                begin
                    idx_reg        <= '0;
                    link_pend_reg  <= 1'b1;
                    link_chain_reg <= (blk_ctrl & FLAG_CHAIN) != 32'd0;
                    link_last_reg  <= ctl.last;
                end
                else
                begin
                    idx_reg <= idx_reg + IW'(1);
                end
            end

            if (link_fire || ctl.fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Request registers and output payload
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            cur_addr_reg <= buffer_address;
            rem_reg      <= length;
            len_reg      <= length;
            dir_reg      <= direction_in;
            cin_reg      <= request_type[7];
            rtype_reg    <= request_type;
            rcode_reg    <= request_code;
            rvalue_reg   <= request_value;
            rindex_reg   <= request_index;
        end
        else if (ctl.fire && (ctl.blk == BLK_NORMAL))
        begin
            cur_addr_reg <= cur_addr_reg + 64'(chunk);
            rem_reg      <= rem_reg - chunk;
        end

        if (link_fire)
            out_reg <= link_res;
        else if (ctl.fire)
            out_reg <= push_res;
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

endmodule

`default_nettype wire

// ----- sv/usb_transfer_trb_ring_producer.sv -----
// Top level of the transfer ring producer: configuration registers, stream
// ports, sequencer and datapath. Depends on utrp_pkg, utrp_sequencer,
// utrp_datapath.
//
//   Port group   Direction  Carries
//   s_*          in         one transfer request per transaction
//   m_*          out        one ring entry, link update or rejection per transaction
//   APB          in/out     ring base, bulk length limit, control length limit
//
// A request is accepted and dispatched by the microcode sequencer, which
// then writes one ring entry per cycle while the result stream does not stall
// and no link update is pending; a link update adds one entry.
// Reset (rst_n low, asynchronous) sets the enqueue index to zero, the
// producer cycle bit to one and the limit registers to 65536 and 4096.
// A stalled m_tready freezes the step counter except at the waiting first
// step; s_tready is high only there and only with no link update pending.
`timescale 1ns / 1ps
`default_nettype none

module usb_transfer_trb_ring_producer
    import utrp_pkg::*;
#(
    parameter int RING_ENTRIES   = RING_ENTRIES_DEF,
    parameter int BOUNDARY_BYTES = BOUNDARY_BYTES_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // configuration port
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [63:0]  pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    // request stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // buffer_address[63:0], length[80:64], direction_in[81], request_type[89:82],
    // request_code[97:90], request_value[113:98], request_index[129:114], zero pad
    input  wire logic [135:0] s_tdata,
    // command[1:0]
    input  wire logic [1:0]   s_tuser,
    // result stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // ring_slot[7:0], entry_address[71:8], block_parameter[135:72],
    // block_status[167:136], block_control[199:168]
    output logic [199:0]      m_tdata,
    // entry_kind[1:0]
    output logic [1:0]        m_tuser,
    // last_of_run
    output logic              m_tlast
);

    logic [63:0] ring_base_reg;
    logic [16:0] bulk_len_reg;
    logic [15:0] ctrl_max_reg;
    logic        cfg_write;

    seq_ctl_t   ctl;
    dp_status_t stat;
    req_kind_t  req_kind;
    result_t    res;

    // Register write and read
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_base_reg <= '0;
            bulk_len_reg  <= BULK_LEN_RST;
            ctrl_max_reg  <= CTRL_MAX_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[4:3])
                REG_RING_BASE: ring_base_reg <= pwdata;
                REG_BULK_LEN:  bulk_len_reg  <= pwdata[16:0];
                REG_CTRL_MAX:  ctrl_max_reg  <= pwdata[15:0];
                default:       ring_base_reg <= ring_base_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:3])
            REG_RING_BASE: prdata = ring_base_reg;
            REG_BULK_LEN:  prdata = 64'(bulk_len_reg);
            REG_CTRL_MAX:  prdata = 64'(ctrl_max_reg);
            default:       prdata = '0;
        endcase
    end

    utrp_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .req_kind (req_kind),
        .stat     (stat),
        .ctl      (ctl)
    );

    utrp_datapath #(
        .RING_ENTRIES   (RING_ENTRIES),
        .BOUNDARY_BYTES (BOUNDARY_BYTES)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .ctl                (ctl),
        .stat               (stat),
        .req_kind           (req_kind),
        .command            (s_tuser),
        .buffer_address     (s_tdata[63:0]),
        .length             (s_tdata[80:64]),
        .direction_in       (s_tdata[81]),
        .request_type       (s_tdata[89:82]),
        .request_code       (s_tdata[97:90]),
        .request_value      (s_tdata[113:98]),
        .request_index      (s_tdata[129:114]),
        .ring_base_address  (ring_base_reg),
        .bulk_buffer_length (bulk_len_reg),
        .control_max_length (ctrl_max_reg),
        .out_valid          (m_tvalid),
        .out_ready          (m_tready),
        .out_result         (res)
    );

    // Pack the result transaction
    assign m_tdata = {res.control, res.status, res.param, res.addr, res.slot};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

    // A link update always targets the last ring slot
    a_link_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == KIND_LINK)) |-> (m_tdata[7:0] == 8'(RING_ENTRIES - 1)))
        else $error("link update not at the link slot");

    // A rejection is the only and so the final result of its request
    a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == KIND_REJECT)) |-> m_tlast)
        else $error("rejection without last_of_run");

    // Once a request is taken, no further one is taken in the next cycle
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while the sequencer is busy");

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for usb_transfer_trb_ring_producer: drives requests and
// APB register writes, predicts every ring entry and checks the result stream.
// Depends on utrp_pkg and the producer RTL only.

module tb_top
    import utrp_pkg::*;
();

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int LINK_SLOT   = RING_ENTRIES_DEF - 1;
    localparam int CYCLE_LIMIT = 400000;

    // Command in the top bits, then the s_tdata payload laid out as on the bus
    typedef struct packed {
        logic [1:0]  command;
        logic [5:0]  pad;
        logic [15:0] req_index;
        logic [15:0] req_value;
        logic [7:0]  req_code;
        logic [7:0]  req_type;
        logic        dir_in;
        logic [16:0] length;
        logic [63:0] buf_addr;
    } request_t;

    // Ring model: register copies, enqueue state and the entries still owed
    class trb_ring_checker;
        logic [63:0] ring_base;
        logic [16:0] bulk_limit;
        logic [15:0] ctrl_max;
        int          enq_index;
        bit          cycle_bit;
        result_t     entries_due[$];
        int          errors;

        function new();
            ring_base  = '0;
            bulk_limit = BULK_LEN_RST;
            ctrl_max   = CTRL_MAX_RST;
            enq_index  = 0;
            cycle_bit  = 1'b1;
            errors     = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [63:0] val);
            case (idx)
                REG_RING_BASE: ring_base  = val;
                REG_BULK_LEN:  bulk_limit = val[16:0];
                REG_CTRL_MAX:  ctrl_max   = val[15:0];
                default: ;
            endcase
        endfunction

        function void add_entry(logic [1:0] kind, int slot, logic [63:0] param,
                                logic [31:0] status, logic [31:0] control);
            result_t e;
            e.kind    = kind;
            e.slot    = slot[7:0];
            e.addr    = (kind == KIND_REJECT) ? 64'h0 : ring_base + 64'(slot) * 64'd16;
            e.param   = param;
            e.status  = status;
            e.control = control;
            e.last    = 1'b0;
            entries_due.push_back(e);
        endfunction

        // Write one block, then the link update once the link slot is reached
        function void push_block(logic [63:0] param, logic [31:0] status,
                                 logic [31:0] control);
            add_entry(KIND_BLOCK, enq_index, param, status,
                      (control & ~32'h1) | 32'(cycle_bit));
            enq_index++;
            if (enq_index >= LINK_SLOT)
            begin
                add_entry(KIND_LINK, LINK_SLOT, ring_base, 32'h0,
                          BT_LINK | FLAG_TOGGLE | (control & FLAG_CHAIN) | 32'(cycle_bit));
                enq_index = 0;
                cycle_bit = ~cycle_bit;
            end
        endfunction

        function logic [16:0] piece_len(logic [63:0] addr, logic [16:0] remaining);
            logic [16:0] room;
            room = 17'(BOUNDARY_BYTES_DEF) - 17'(addr % 64'(BOUNDARY_BYTES_DEF));
            return (remaining < room) ? remaining : room;
        endfunction

        function void note_request(request_t rq);
            logic [16:0] off;
            logic [16:0] chunk;
            logic [63:0] p;
            logic [31:0] trt;
            int          pieces;
            bit          reject;
            bit          dev_in;
            reject = 1'b0;
            case (rq.command)
                CMD_BULK:
                begin
                    if (rq.length > bulk_limit)
                        reject = 1'b1;
                    else
                    begin
                        // count the boundary pieces first
                        off    = '0;
                        pieces = 0;
                        do
                        begin
                            off += piece_len(rq.buf_addr + 64'(off), rq.length - off);
                            pieces++;
                        end while (off < rq.length && pieces <= 3);
                        if (pieces > 3)
                            reject = 1'b1;
                    end
                    if (!reject)
                    begin
                        off = '0;
                        do
                        begin
                            p     = rq.buf_addr + 64'(off);
                            chunk = piece_len(p, rq.length - off);
                            push_block(p, 32'(chunk),
                                       BT_NORMAL |
                                       ((off + chunk >= rq.length) ? FLAG_IOC : FLAG_CHAIN) |
                                       (rq.dir_in ? FLAG_ISP : 32'h0));
                            off += chunk;
                        end while (off < rq.length);
                    end
                end
                CMD_CONTROL:
                begin
                    if (rq.length > 17'(ctrl_max))
                        reject = 1'b1;
                    else
                    begin
                        dev_in = rq.req_type[7];
                        trt    = (rq.length == 0) ? 32'h0 : (dev_in ? TRT_IN : TRT_OUT);
                        push_block({rq.length[15:0], rq.req_index, rq.req_value,
                                    rq.req_code, rq.req_type},
                                   SETUP_LEN, BT_SETUP | FLAG_IDT | trt);
                        if (rq.length != 0)
                            push_block(rq.buf_addr, 32'(rq.length),
                                       BT_DATA | (dev_in ? FLAG_DIR : 32'h0));
                        push_block(64'h0, 32'h0, BT_STATUS | FLAG_IOC |
                                   ((rq.length != 0 && dev_in) ? 32'h0 : FLAG_DIR));
                    end
                end
                CMD_INTR:
                    push_block(rq.buf_addr, 32'(rq.length), BT_NORMAL | FLAG_IOC | FLAG_ISP);
                default:
                    reject = 1'b1;
            endcase
            if (reject)
                add_entry(KIND_REJECT, 0, 64'h0, 32'h0, 32'h0);
            entries_due[entries_due.size() - 1].last = 1'b1;
        endfunction

        function void compare(string field, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                errors++;
                $error("%s mismatch: expected %h, actual %h", field, want, got);
            end
        endfunction

        function void check_entry(result_t got);
            result_t want;
            if (entries_due.size() == 0)
            begin
                errors++;
                $error("unexpected ring entry: kind %0d slot %0d", got.kind, got.slot);
                return;
            end
            want = entries_due.pop_front();
            compare("entry_kind", 64'(want.kind), 64'(got.kind));
            compare("ring_slot", 64'(want.slot), 64'(got.slot));
            compare("entry_address", want.addr, got.addr);
            compare("block_parameter", want.param, got.param);
            compare("block_status", 64'(want.status), 64'(got.status));
            compare("block_control", 64'(want.control), 64'(got.control));
            compare("last_of_run", 64'(want.last), 64'(got.last));
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [63:0]  pwdata;
    logic [63:0]  prdata;
    logic         pready;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [199:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;

    bit          idle_on;
    logic [16:0] bulk_limit_now;
    logic [15:0] ctrl_max_now;
    int          cycles;
    trb_ring_checker ring_sb = new();

    usb_transfer_trb_ring_producer uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
        clk = 1'b0;

    always #1 clk = ~clk;

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Sample both streams at the rising edge
    always @(posedge clk)
    begin : monitor
        result_t got;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                ring_sb.note_request({s_tuser, s_tdata});
            if (m_tvalid && m_tready)
            begin
                got.slot    = m_tdata[7:0];
                got.addr    = m_tdata[71:8];
                got.param   = m_tdata[135:72];
                got.status  = m_tdata[167:136];
                got.control = m_tdata[199:168];
                got.kind    = m_tuser;
                got.last    = m_tlast;
                ring_sb.check_entry(got);
            end
        end
    end

    // Stall the result stream at random
    always @(negedge clk)
        m_tready = idle_on ? ($urandom_range(99) >= 10) : 1'b1;

    task automatic write_register(logic [1:0] idx, logic [63:0] val);
        @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 3'b000};
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        ring_sb.set_register(idx, val);
        if (idx == REG_BULK_LEN)
            bulk_limit_now = val[16:0];
        if (idx == REG_CTRL_MAX)
            ctrl_max_now = val[15:0];
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Hold one request on the bus until the transaction completes
    task automatic send_request(request_t rq);
        @(negedge clk);
        while (idle_on && $urandom_range(99) < 10)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = rq.command;
        s_tdata  = rq[135:0];
        do @(posedge clk); while (!s_tready);
    endtask

    // Let every owed entry arrive, then allow the sequencer to settle
    task automatic drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (ring_sb.entries_due.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    function automatic request_t make_request(logic [1:0] command, logic [63:0] buf_addr,
                                              logic [16:0] length, logic dir_in,
                                              logic [7:0] req_type, logic [7:0] req_code,
                                              logic [15:0] req_value, logic [15:0] req_index);
        request_t rq;
        rq.command   = command;
        rq.pad       = '0;
        rq.buf_addr  = buf_addr;
        rq.length    = length;
        rq.dir_in    = dir_in;
        rq.req_type  = req_type;
        rq.req_code  = req_code;
        rq.req_value = req_value;
        rq.req_index = req_index;
        return rq;
    endfunction

    function automatic request_t random_request();
        request_t    rq;
        int          pick;
        logic [16:0] limit;
        rq     = request_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
        rq.pad = '0;
        pick   = $urandom_range(99);
        rq.command = (pick < 45) ? CMD_BULK : (pick < 80) ? CMD_CONTROL :
                     (pick < 95) ? CMD_INTR : CMD_UNUSED;
        // bias buffers towards a 64 KiB boundary or low memory
        case ($urandom_range(3))
            0: rq.buf_addr[15:0] = 16'hFFFF - 16'($urandom_range(255));
            1: rq.buf_addr = 64'($urandom_range(65535));
            default: ;
        endcase
        limit = (rq.command == CMD_CONTROL) ? 17'(ctrl_max_now) : bulk_limit_now;
        case ($urandom_range(7))
            0: rq.length = '0;
            1: rq.length = 17'($urandom_range(1, 64));
            2: rq.length = 17'h1_0000;
            3: rq.length = limit;
            4: rq.length = (limit < 17'h1_0000) ? limit + 17'd1 : limit;
            5: rq.length = 17'($urandom_range(0, limit));
            default: rq.length = 17'($urandom_range(0, 65536));
        endcase
        return rq;
    endfunction

    task automatic run_random(int count, int quiet_from, int quiet_to);
        for (int i = 0; i < count; i++)
        begin
            idle_on = !(i >= quiet_from && i < quiet_to);
            send_request(random_request());
        end
        idle_on = 1'b1;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = CMD_BULK;
        m_tready       = 1'b0;
        idle_on        = 1'b1;
        cycles         = 0;
        bulk_limit_now = BULK_LEN_RST;
        ctrl_max_now   = CTRL_MAX_RST;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset limits: empty bulk, boundary splits, every control shape, interrupts and an unused command
        send_request(make_request(CMD_BULK, 64'h0, 17'd0, 1'b0, 8'h00, 8'h00, 16'h0, 16'h0));
        send_request(make_request(CMD_BULK, 64'h0, 17'h1_0000, 1'b1,
                                  8'h00, 8'h00, 16'h0, 16'h0));
        send_request(make_request(CMD_BULK, 64'hFFFF_FFFF_FFFF_FFF0, 17'h1_0000, 1'b1,
                                  8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF));
        send_request(make_request(CMD_BULK, 64'h0000_0001_2345_8000, 17'h0_8000, 1'b0,
                                  8'h00, 8'h00, 16'h0, 16'h0));
        send_request(make_request(CMD_BULK, 64'h8000, 17'h0_8001, 1'b0,
                                  8'h00, 8'h00, 16'h0, 16'h0));
        send_request(make_request(CMD_BULK, 64'h1, 17'h1_0000, 1'b1,
                                  8'h00, 8'h00, 16'h0, 16'h0));
        send_request(make_request(CMD_CONTROL, 64'h0000_7000_0000_1000, 17'd18, 1'b0,
                                  8'h80, 8'h06, 16'h0100, 16'h0000));
        send_request(make_request(CMD_CONTROL, 64'h0, 17'd0, 1'b0,
                                  8'h00, 8'h09, 16'h0001, 16'h0000));
        send_request(make_request(CMD_CONTROL, 64'h0, 17'd0, 1'b0,
                                  8'h80, 8'h00, 16'h0000, 16'h0000));
        send_request(make_request(CMD_CONTROL, 64'hDEAD_BEEF_0000_0040, 17'd4096, 1'b0,
                                  8'h21, 8'h01, 16'h5A5A, 16'h00A5));
        send_request(make_request(CMD_CONTROL, 64'h0, 17'd4097, 1'b0,
                                  8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF));
        send_request(make_request(CMD_CONTROL, 64'h0, 17'h1_0000, 1'b1,
                                  8'h80, 8'h06, 16'h0200, 16'h0000));
        send_request(make_request(CMD_CONTROL, 64'hFFFF_FFFF_FFFF_FFFF, 17'd7, 1'b1,
                                  8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF));
        send_request(make_request(CMD_INTR, 64'hFFFF_FFFF_FFFF_FFFF, 17'h1_0000, 1'b1,
                                  8'h00, 8'h00, 16'h0, 16'h0));
        send_request(make_request(CMD_INTR, 64'h0, 17'd0, 1'b0, 8'h00, 8'h00, 16'h0, 16'h0));
        send_request(make_request(CMD_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 17'h1_0000, 1'b1,
                                  8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF));
        drain();

        // Tight limits and a base that makes entry addresses wrap
        write_register(REG_RING_BASE, 64'hFFFF_FFFF_FFFF_FFF0);
        write_register(REG_BULK_LEN, 64'd100);
        write_register(REG_CTRL_MAX, 64'd0);
        send_request(make_request(CMD_BULK, 64'h0000_0000_0000_FFC0, 17'd100, 1'b0,
                                  8'h00, 8'h00, 16'h0, 16'h0));
        send_request(make_request(CMD_BULK, 64'h0, 17'd101, 1'b0, 8'h00, 8'h00, 16'h0, 16'h0));
        send_request(make_request(CMD_CONTROL, 64'h0, 17'd0, 1'b0,
                                  8'h80, 8'h05, 16'h0003, 16'h0000));
        send_request(make_request(CMD_CONTROL, 64'h0, 17'd1, 1'b0,
                                  8'h80, 8'h05, 16'h0003, 16'h0000));
        run_random(30, 0, 0);
        drain();

        // Widest limits, with a stretch free of idling on both sides
        write_register(REG_RING_BASE, {$urandom, $urandom} & ~64'hF);
        write_register(REG_BULK_LEN, 64'h1_0000);
        write_register(REG_CTRL_MAX, 64'hFFFF);
        send_request(make_request(CMD_CONTROL, 64'h0000_0000_4000_0000, 17'hFFFF, 1'b0,
                                  8'h80, 8'h06, 16'h0300, 16'h0409));
        send_request(make_request(CMD_CONTROL, 64'h0, 17'h1_0000, 1'b0,
                                  8'h00, 8'h00, 16'h0, 16'h0));
        run_random(200, 60, 160);
        drain();

        // Random limits
        write_register(REG_RING_BASE, 64'h0);
        write_register(REG_BULK_LEN, 64'($urandom_range(0, 65536)));
        write_register(REG_CTRL_MAX, 64'($urandom_range(0, 65535)));
        run_random(140, 0, 0);
        drain();

        // Back to the reset limits
        write_register(REG_RING_BASE, {$urandom, $urandom} & ~64'hF);
        write_register(REG_BULK_LEN, 64'(BULK_LEN_RST));
        write_register(REG_CTRL_MAX, 64'(CTRL_MAX_RST));
        run_random(80, 0, 0);
        drain();

        if (ring_sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
